/* design/ibme_pkg.sv */
package ibme_pkg;

  localparam int DELAY_WIDTH_DEF = 16;
  localparam int QUARTER_WIDTH   = 16;
  localparam logic [QUARTER_WIDTH-1:0] QUARTER_RESET = 16'd100;

  localparam int BYTE_BITS = 8;
  localparam int BIT_CNT_W = 4;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 4'd7;

  // command codes
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_STOP      = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_READ_ACK  = 3'd3;
  localparam logic [2:0] OP_READ_NACK = 3'd4;

  typedef enum logic [15:0] {
    PH_IDLE = 16'b0000_0000_0000_0001,
    PH_ST_A = 16'b0000_0000_0000_0010,
    PH_ST_B = 16'b0000_0000_0000_0100,
    PH_ST_C = 16'b0000_0000_0000_1000,
    PH_SP_A = 16'b0000_0000_0001_0000,
    PH_WR_D = 16'b0000_0000_0010_0000,
    PH_WR_H = 16'b0000_0000_0100_0000,
    PH_WR_L = 16'b0000_0000_1000_0000,
    PH_AK_R = 16'b0000_0001_0000_0000,
    PH_AK_H = 16'b0000_0010_0000_0000,
    PH_AK_L = 16'b0000_0100_0000_0000,
    PH_RD_H = 16'b0000_1000_0000_0000,
    PH_RD_L = 16'b0001_0000_0000_0000,
    PH_RA_R = 16'b0010_0000_0000_0000,
    PH_RA_H = 16'b0100_0000_0000_0000,
    PH_RA_L = 16'b1000_0000_0000_0000
  } ibme_phase_t;

  typedef struct packed {
    logic                 cmd_valid;
    logic [2:0]           operation;
    logic [BYTE_BITS-1:0] cmd_byte;
    logic                 sda_in;
  } ibme_item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 ready_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] read_data;
    logic                 ack_missing;
  } ibme_res_t;

endpackage

/* design/ibme_in_reg.sv */
module ibme_in_reg import ibme_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       step,
  input  ibme_item_t item_in,
  output logic       valid,
  output ibme_item_t item_out
);

  logic       valid_r;
  ibme_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (step) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule

/* design/ibme_engine.sv */
module ibme_engine import ibme_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  ibme_item_t               item,
  input  logic [QUARTER_WIDTH-1:0] quarter_ticks,
  output ibme_res_t                res
);

  ibme_phase_t          phase_r, phase_nxt;
  logic [2:0]           act_cmd_r, act_cmd_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [BIT_CNT_W-1:0] bit_inc;
  logic [DELAY_WIDTH-1:0] delay_r, delay_nxt;
  logic [BYTE_BITS-1:0] shift_r, shift_nxt;
  logic [BYTE_BITS-1:0] rd_latch_r, rd_latch_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 ack_r, ack_nxt;
  logic                 done;

  // delay reload: masked to the counter width, zero counts as one tick
  logic [QUARTER_WIDTH+DELAY_WIDTH-1:0] q_ext;
  logic [DELAY_WIDTH-1:0]               q_mask;
  logic [DELAY_WIDTH-1:0]               reload;

  assign q_ext   = {{DELAY_WIDTH{1'b0}}, quarter_ticks};
  assign q_mask  = q_ext[DELAY_WIDTH-1:0];
  assign reload  = (q_mask == '0) ? '0 : q_mask - 1'b1;
  assign bit_inc = bit_cnt_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    act_cmd_nxt  = act_cmd_r;
    bit_cnt_nxt  = bit_cnt_r;
    delay_nxt    = delay_r;
    shift_nxt    = shift_r;
    rd_latch_nxt = rd_latch_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ack_nxt      = ack_r;
    done         = 1'b0;
    if (step_en) begin
      if (phase_r == PH_IDLE) begin
        if (item.cmd_valid && item.operation <= OP_READ_NACK) begin
          act_cmd_nxt = item.operation;
          bit_cnt_nxt = '0;
          delay_nxt   = reload;
          case (item.operation)
            OP_START: begin
              sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = PH_ST_A;
            end
            OP_STOP: begin
              sda_nxt = 1'b0; scl_nxt = 1'b1; phase_nxt = PH_SP_A;
            end
            OP_WRITE: begin
              shift_nxt = item.cmd_byte;
              sda_nxt   = item.cmd_byte[BYTE_BITS-1];
              phase_nxt = PH_WR_D;
            end
            default: begin
              shift_nxt = '0;
              sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = PH_RD_H;
            end
          endcase
        end
      end else if (delay_r != '0) begin
        delay_nxt = delay_r - 1'b1;
      end else begin
        delay_nxt = reload;
        case (phase_r)
          PH_ST_A: begin sda_nxt = 1'b0; phase_nxt = PH_ST_B; end
          PH_ST_B: begin scl_nxt = 1'b0; phase_nxt = PH_ST_C; end
          PH_ST_C: begin phase_nxt = PH_IDLE; delay_nxt = '0; done = 1'b1; end
          PH_SP_A: begin
            sda_nxt = 1'b1; phase_nxt = PH_IDLE; delay_nxt = '0; done = 1'b1;
          end
          PH_WR_D: begin scl_nxt = 1'b1; phase_nxt = PH_WR_H; end
          PH_WR_H: begin
            scl_nxt = 1'b0;
            if (bit_cnt_r == LAST_BIT) begin
              sda_nxt = 1'b1;
            end
            shift_nxt = {shift_r[BYTE_BITS-2:0], 1'b0};
            phase_nxt = PH_WR_L;
          end
          PH_WR_L: begin
            bit_cnt_nxt = bit_inc;
            if (!bit_inc[BIT_CNT_W-1]) begin
              sda_nxt   = shift_r[BYTE_BITS-1];
              phase_nxt = PH_WR_D;
            end else begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_AK_R;
            end
          end
          PH_AK_R: begin scl_nxt = 1'b1; phase_nxt = PH_AK_H; end
          PH_AK_H: begin
            ack_nxt = item.sda_in; scl_nxt = 1'b0; phase_nxt = PH_AK_L;
          end
          PH_AK_L: begin phase_nxt = PH_IDLE; delay_nxt = '0; done = 1'b1; end
          PH_RD_H: begin
            shift_nxt = {shift_r[BYTE_BITS-2:0], item.sda_in};
            scl_nxt   = 1'b0;
            phase_nxt = PH_RD_L;
          end
          PH_RD_L: begin
            bit_cnt_nxt = bit_inc;
            if (!bit_inc[BIT_CNT_W-1]) begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_RD_H;
            end else begin
              rd_latch_nxt = shift_r;
              sda_nxt      = (act_cmd_r == OP_READ_ACK) ? 1'b0 : 1'b1;
              phase_nxt    = PH_RA_R;
            end
          end
          PH_RA_R: begin scl_nxt = 1'b1; phase_nxt = PH_RA_H; end
          PH_RA_H: begin scl_nxt = 1'b0; phase_nxt = PH_RA_L; end
          default: begin
            // end of the read acknowledge slot: release sda after an ack
            if (act_cmd_r == OP_READ_ACK) begin
              sda_nxt = 1'b1;
            end
            phase_nxt = PH_IDLE;
            delay_nxt = '0;
            done      = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      act_cmd_r  <= '0;
      bit_cnt_r  <= '0;
      delay_r    <= '0;
      shift_r    <= '0;
      rd_latch_r <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      act_cmd_r  <= act_cmd_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      delay_r    <= delay_nxt;
      shift_r    <= shift_nxt;
      rd_latch_r <= rd_latch_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_r      <= ack_nxt;
    end
  end

  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_level   = sda_nxt;
    res.ready_res   = (phase_nxt == PH_IDLE);
    res.done_res    = done;
    res.read_data   = rd_latch_nxt;
    res.ack_missing = ack_nxt;
  end

  a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> delay_r == '0)
    else $error("delay counter running while idle");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && done |=> phase_r == PH_IDLE)
    else $error("done without returning to idle");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter past byte length");

  a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(delay_r))
    else $error("state moved without a tick");

endmodule

/* design/ibme_out_reg.sv */
module ibme_out_reg import ibme_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      taken,
  input  ibme_res_t res_in,
  output logic      valid,
  output ibme_res_t res_out
);

  logic      valid_r;
  ibme_res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (taken) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

/* design/i2c_byte_master_engine.sv */
// i2c master bit engine, one input word per bus timing tick
// an accepted input word passes the input register, then the result register, to its result word
// throughput: one word per cycle unless out_tready stalls; both streams may run every cycle
// the engine state advances once per accepted word; delays are counted in words
// reset (rst_n low, synchronous): idle, scl and sda released, read byte and ack flag 0,
// delay register back to 100, both word registers empty
module i2c_byte_master_engine import ibme_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command and sda sample words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] cmd_valid, [8:1] cmd_byte, [9] sda_in, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] operation
  // bus drive and status words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] scl_level, [1] sda_level, [2] ready_res,
                                  // [3] done_res, [11:4] read_data, [12] ack_missing
  // delay register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [QUARTER_WIDTH-1:0] quarter_r;
  ibme_item_t in_item, s1_item;
  ibme_res_t  eng_res, out_res;
  logic       s1_valid;
  logic       step;
  logic       in_fire;

  // delay register, the user writes it only while the stream is drained; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quarter_r <= QUARTER_RESET;
    end else if (cfg_valid) begin
      quarter_r <= cfg_data;
    end
  end

  // unpack the input word
  always_comb begin
    in_item.cmd_valid = in_tdata[0];
    in_item.cmd_byte  = in_tdata[8:1];
    in_item.sda_in    = in_tdata[9];
    in_item.operation = in_tuser;
  end

  // a tick runs when the held word exists and the result slot is free or draining
  assign step      = s1_valid && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid || step;
  assign in_fire   = in_tvalid && in_tready;

  ibme_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .step     (step),
    .item_in  (in_item),
    .valid    (s1_valid),
    .item_out (s1_item)
  );

  ibme_engine #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step),
    .item          (s1_item),
    .quarter_ticks (quarter_r),
    .res           (eng_res)
  );

  ibme_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step),
    .taken   (out_tready),
    .res_in  (eng_res),
    .valid   (out_tvalid),
    .res_out (out_res)
  );

  // pack the result word
  assign out_tdata = {3'b000, out_res.ack_missing, out_res.read_data, out_res.done_res,
                      out_res.ready_res, out_res.sda_level, out_res.scl_level};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with a free result slot");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("tick produced no result word");

  a_held_word_steps: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && out_tready |-> step)
    else $error("held word not processed while output drains");

endmodule

/* tb/tb_i2c_byte_master_engine.sv */
module tb_i2c_byte_master_engine;
  import ibme_pkg::*;

  // clock and run control
  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int STALL_LIMIT   = 2000;   // cycles with no word moving on any channel
  localparam int DRAIN_TAIL    = 20;     // a few times the pipeline through input and result register
  localparam int WORDS_PER_LAP = 470;    // random words per idling setting
  localparam int HOLD_CYCLES   = 300;    // long receiver hold-off, fills the pipeline

  // operation codes the engine must ignore
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // delay register settings
  localparam logic [15:0] DELAY_ZERO = 16'd0;
  localparam logic [15:0] DELAY_MIN  = 16'd1;
  localparam logic [15:0] DELAY_MAX  = 16'hFFFF;

  // result word of an idle engine straight out of reset
  localparam ibme_res_t IDLE_AT_RESET = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam ibme_res_t NOT_TYPED     = '0;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] wbyte;
  } bus_cmd_t;

  // one directed row: a command offered on every word until the row ends
  typedef struct {
    bit          wr_cfg;     // write the delay register before the row
    logic [15:0] cfg_val;
    logic        valid;
    logic [2:0]  op;
    logic [7:0]  wbyte;
    logic [7:0]  dev_byte;   // byte the device puts on sda during a read
    logic        dev_ack;    // sda level outside the read bits
    int          words;      // 0: run until the engine is idle again
    bit          chk;        // first word's result typed in below
    ibme_res_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  i2c_byte_master_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [0] cmd_valid, [8:1] cmd_byte, [9] sda_in, rest zero
    .in_tuser   (in_tuser),   // [2:0] operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] scl, [1] sda, [2] ready, [3] done, [11:4] read, [12] ack
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // engine copy kept by the bench, advanced once per accepted input word
  logic [15:0] quarter_ticks = QUARTER_RESET;
  ibme_phase_t ph            = PH_IDLE;
  logic [2:0]  act_op        = OP_START;
  logic [3:0]  bit_cnt       = '0;
  logic [15:0] delay_left    = '0;
  logic [7:0]  shreg         = '0;
  logic        scl_drv       = 1'b1;
  logic        sda_drv       = 1'b1;
  logic        ack_flag      = 1'b0;
  logic [7:0]  rd_latch      = '0;

  ibme_res_t expected_words[$];
  bus_cmd_t  bus_plan[$];
  dir_row_t  dir_rows[$];

  int mismatches   = 0;
  int snd_idle_pct = 28;
  int rcv_idle_pct = 68;
  bit hold_req     = 1'b0;
  int stall_cycles = 0;

  // move to the next phase and load one bus delay; a zero register counts as one tick
  function automatic void enter(ibme_phase_t nxt);
    ph = nxt;
    delay_left = (quarter_ticks == '0) ? '0 : quarter_ticks - 16'd1;
  endfunction

  // one tick of the bit engine, returns the result word it produces
  function automatic ibme_res_t engine_tick(logic valid, logic [2:0] op, logic [7:0] wbyte,
                                            logic sda);
    logic fin;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      // commands only start from idle, unknown codes are dropped
      if (valid && op <= OP_READ_NACK) begin
        act_op  = op;
        bit_cnt = '0;
        case (op)
          OP_START: begin
            sda_drv = 1'b1;
            scl_drv = 1'b1;
            enter(PH_ST_A);
          end
          OP_STOP: begin
            sda_drv = 1'b0;
            scl_drv = 1'b1;
            enter(PH_SP_A);
          end
          OP_WRITE: begin
            shreg   = wbyte;
            sda_drv = shreg[7];
            enter(PH_WR_D);
          end
          default: begin
            shreg   = '0;
            sda_drv = 1'b1;
            scl_drv = 1'b1;
            enter(PH_RD_H);
          end
        endcase
      end
    end else if (delay_left != '0) begin
      delay_left = delay_left - 16'd1;
    end else begin
      case (ph)
        PH_ST_A: begin
          sda_drv = 1'b0;
          enter(PH_ST_B);
        end
        PH_ST_B: begin
          scl_drv = 1'b0;
          enter(PH_ST_C);
        end
        PH_ST_C: fin = 1'b1;
        PH_SP_A: begin
          // stop finishes on the same tick sda is released
          sda_drv = 1'b1;
          fin = 1'b1;
        end
        PH_WR_D: begin
          scl_drv = 1'b1;
          enter(PH_WR_H);
        end
        PH_WR_H: begin
          scl_drv = 1'b0;
          if (bit_cnt == LAST_BIT) sda_drv = 1'b1;
          shreg = {shreg[6:0], 1'b0};
          enter(PH_WR_L);
        end
        PH_WR_L: begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt < BYTE_BITS) begin
            sda_drv = shreg[7];
            enter(PH_WR_D);
          end else begin
            sda_drv = 1'b1;
            enter(PH_AK_R);
          end
        end
        PH_AK_R: begin
          scl_drv = 1'b1;
          enter(PH_AK_H);
        end
        PH_AK_H: begin
          // device ack sampled as scl goes low
          ack_flag = sda;
          scl_drv = 1'b0;
          enter(PH_AK_L);
        end
        PH_AK_L: fin = 1'b1;
        PH_RD_H: begin
          shreg = {shreg[6:0], sda};
          scl_drv = 1'b0;
          enter(PH_RD_L);
        end
        PH_RD_L: begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt < BYTE_BITS) begin
            scl_drv = 1'b1;
            enter(PH_RD_H);
          end else begin
            rd_latch = shreg;
            sda_drv = (act_op == OP_READ_ACK) ? 1'b0 : 1'b1;
            enter(PH_RA_R);
          end
        end
        PH_RA_R: begin
          scl_drv = 1'b1;
          enter(PH_RA_H);
        end
        PH_RA_H: begin
          scl_drv = 1'b0;
          enter(PH_RA_L);
        end
        default: begin
          // end of a read: an acked read releases sda on the done tick
          if (act_op == OP_READ_ACK) sda_drv = 1'b1;
          fin = 1'b1;
        end
      endcase
    end
    if (fin) begin
      ph = PH_IDLE;
      delay_left = '0;
    end
    return {scl_drv, sda_drv, (ph == PH_IDLE), fin, rd_latch, ack_flag};
  endfunction

  // offer one input word, called on a falling edge and returns on one
  task automatic send_word(input logic valid, input logic [2:0] op, input logic [7:0] wbyte,
                           input logic sda, input bit typed, input ibme_res_t typed_res);
    ibme_res_t res;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, sda, wbyte, valid};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = engine_tick(valid, op, wbyte, sda);
    expected_words.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // delay register write once every result word is back
  task automatic write_delay(input logic [15:0] val);
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    quarter_ticks = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random ready, with one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // result words against the oldest expectation
  always @(posedge clk) begin
    ibme_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("scl_level",   want.scl_level,   out_tdata[0]);
        check_field("sda_level",   want.sda_level,   out_tdata[1]);
        check_field("ready_res",   want.ready_res,   out_tdata[2]);
        check_field("done_res",    want.done_res,    out_tdata[3]);
        check_field("read_data",   want.read_data,   out_tdata[11:4]);
        check_field("ack_missing", want.ack_missing, out_tdata[12]);
      end
    end
  end

  // watchdog on cycles where no word moves anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int       n;
    int       lap;
    int       w;
    int       extra;
    logic     valid;
    logic     sda;
    logic [2:0] op;
    logic [7:0] wb;
    bus_cmd_t cmd;

    // directed rows: idle, unknown codes, every command at delay one, zero delay,
    // a register write in the middle of a command, and the largest delay written while idle
    dir_rows.push_back('{1'b0, 16'd0, 1'b0, OP_START, 8'h00, 8'h00, 1'b0, 1, 1'b1,
                         IDLE_AT_RESET});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_UNUSED_LO, 8'hFF, 8'h00, 1'b1, 1, 1'b1,
                         IDLE_AT_RESET});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_UNUSED_HI, 8'h00, 8'h00, 1'b0, 1, 1'b1,
                         IDLE_AT_RESET});
    dir_rows.push_back('{1'b1, DELAY_MIN, 1'b1, OP_START, 8'h00, 8'h00, 1'b0, 0, 1'b1,
                         {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_WRITE, 8'hFF, 8'h00, 1'b1, 0, 1'b1,
                         {1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_WRITE, 8'h00, 8'h00, 1'b0, 0, 1'b1,
                         {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1}});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_READ_ACK, 8'h00, 8'hFF, 1'b1, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_READ_NACK, 8'hFF, 8'h00, 1'b0, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_READ_ACK, 8'h00, 8'hA5, 1'b0, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_WRITE, 8'h5A, 8'h00, 1'b0, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_WRITE, 8'hC3, 8'h00, 1'b1, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_STOP, 8'h00, 8'h00, 1'b1, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b1, DELAY_ZERO, 1'b1, OP_START, 8'h00, 8'h00, 1'b0, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_WRITE, 8'h81, 8'h00, 1'b0, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_READ_NACK, 8'h00, 8'h3C, 1'b1, 0, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b0, 16'd0, 1'b1, OP_STOP, 8'h00, 8'h00, 1'b1, 0, 1'b0,
                         NOT_TYPED});
    // start left in its first hold, then the register changes under it
    dir_rows.push_back('{1'b1, 16'd3, 1'b1, OP_START, 8'h00, 8'h00, 1'b1, 3, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b1, 16'd2, 1'b0, OP_STOP, 8'h00, 8'h00, 1'b1, 0, 1'b0,
                         NOT_TYPED});
    // largest delay held while idle, no command offered
    dir_rows.push_back('{1'b1, DELAY_MAX, 1'b0, OP_STOP, 8'h00, 8'h00, 1'b1, 2, 1'b0,
                         NOT_TYPED});
    dir_rows.push_back('{1'b1, DELAY_MIN, 1'b0, OP_START, 8'h00, 8'h00, 1'b1, 1, 1'b0,
                         NOT_TYPED});

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, the row's command is repeated while busy so it is ignored there
    foreach (dir_rows[r]) begin
      if (dir_rows[r].wr_cfg) write_delay(dir_rows[r].cfg_val);
      n = 0;
      do begin
        sda = (ph == PH_RD_H) ? dir_rows[r].dev_byte[3'd7 - bit_cnt[2:0]] : dir_rows[r].dev_ack;
        send_word(dir_rows[r].valid, dir_rows[r].op, dir_rows[r].wbyte, sda,
                  dir_rows[r].chk && n == 0, dir_rows[r].want);
        n++;
      end while (dir_rows[r].words != 0 ? n < dir_rows[r].words : ph != PH_IDLE);
    end

    // random part: mostly well formed transfers, some noise and broken sequences
    for (lap = 0; lap < 3; lap++) begin
      case (lap)
        0: begin
          snd_idle_pct = 28;
          rcv_idle_pct = 68;
          write_delay(16'($urandom_range(1, 3)));
        end
        1: begin
          snd_idle_pct = 68;
          rcv_idle_pct = 28;
          write_delay(16'($urandom_range(2, 4)));
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          write_delay(DELAY_MIN);
        end
      endcase
      for (w = 0; w < WORDS_PER_LAP; w++) begin
        if (lap == 0 && w == 120) hold_req = 1'b1;
        if (bus_plan.size() == 0) begin
          // mostly a start, address, up to three data bytes, maybe a closing nack read, mostly a stop
          if ($urandom_range(9) != 0) bus_plan.push_back({OP_START, 8'h00});
          bus_plan.push_back({OP_WRITE, 8'($urandom)});
          extra = $urandom_range(3);
          repeat (extra) begin
            bus_plan.push_back({($urandom_range(1) ? OP_WRITE : OP_READ_ACK), 8'($urandom)});
          end
          if ($urandom_range(1)) bus_plan.push_back({OP_READ_NACK, 8'($urandom)});
          if ($urandom_range(9) != 0) bus_plan.push_back({OP_STOP, 8'h00});
        end
        if (ph == PH_IDLE && $urandom_range(99) < 85) begin
          cmd   = bus_plan.pop_front();
          valid = 1'b1;
          op    = cmd.op;
          wb    = cmd.wbyte;
        end else begin
          // noise: busy offers, unknown codes, stray commands while idle
          valid = (ph == PH_IDLE) ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
          op    = 3'($urandom_range(7));
          wb    = 8'($urandom);
        end
        // device mostly acks; every other sda sample is random
        sda = (ph == PH_AK_H) ? ($urandom_range(9) == 0) : 1'($urandom_range(1));
        send_word(valid, op, wb, sda, 1'b0, NOT_TYPED);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* i2c_byte_master_engine.f */
design/ibme_pkg.sv
design/ibme_in_reg.sv
design/ibme_engine.sv
design/ibme_out_reg.sv
design/i2c_byte_master_engine.sv
tb/tb_i2c_byte_master_engine.sv
